// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the framebuffer RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define TLFB_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TLFB_ASSERT(lbl, prop, msg) `TLFB_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)
`else
`define TLFB_ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define TLFB_ASSERT(lbl, prop, msg)
`endif

`endif

// ===== rtl/tlfb_pkg.sv =====
// Types and constants of the two-layer framebuffer
`timescale 1ns / 1ps
package tlfb_pkg;

  localparam int unsigned WORD_W   = 32;
  localparam int unsigned COLOR_W  = 2;
  localparam int unsigned RGB_W    = 12;
  localparam int unsigned COORD_W  = 10;
  localparam int unsigned APB_AW   = 4;
  localparam int unsigned APB_DW   = 32;
  localparam int unsigned PAL_SIZE = 4;

  localparam logic [3:0] CMD_NIBBLE = 4'hF;
  localparam int unsigned CMD_LAYER_BIT = 22;
  localparam int unsigned CMD_TOP_BIT   = 21;
  localparam int unsigned CMD_LEFT_BIT  = 20;
  localparam int unsigned CMD_X_LSB     = 10;
  localparam int unsigned CMD_Y_LSB     = 0;

  typedef enum logic [1:0] {
    PAL_ZERO  = 2'd0,
    PAL_ONE   = 2'd1,
    PAL_TWO   = 2'd2,
    PAL_THREE = 2'd3
  } tlfb_reg_e;

  localparam logic [RGB_W-1:0] PAL_RESET_ZERO  = 12'hFFF;
  localparam logic [RGB_W-1:0] PAL_RESET_ONE   = 12'h000;
  localparam logic [RGB_W-1:0] PAL_RESET_TWO   = 12'h7DB;
  localparam logic [RGB_W-1:0] PAL_RESET_THREE = 12'hF62;

  typedef struct packed {
    logic bg;
    logic fg;
  } tlfb_we_t;

endpackage

// ===== rtl/tlfb_in_if.sv =====
// Input item channel of the framebuffer
`timescale 1ns / 1ps
interface tlfb_in_if;
  import tlfb_pkg::*;

  logic                valid;
  logic                ready;
  logic                drawing_active;
  logic                write_enable;
  logic                write_layer;
  logic [WORD_W-1:0]   write_word;
  logic [COLOR_W-1:0]  pixel_value;

  modport source (
    output valid, drawing_active, write_enable, write_layer, write_word, pixel_value,
    input  ready
  );
  modport sink (
    input  valid, drawing_active, write_enable, write_layer, write_word, pixel_value,
    output ready
  );
endinterface

// ===== rtl/tlfb_out_if.sv =====
// Result item channel of the framebuffer
`timescale 1ns / 1ps
interface tlfb_out_if;
  import tlfb_pkg::*;

  logic              valid;
  logic              ready;
  logic [RGB_W-1:0]  rgb_color;
  logic              fill_busy;

  modport source (
    output valid, rgb_color, fill_busy,
    input  ready
  );
  modport sink (
    input  valid, rgb_color, fill_busy,
    output ready
  );
endinterface

// ===== rtl/tlfb_ram.sv =====
// Generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps
module tlfb_ram #(
  parameter int unsigned WIDTH = 2,
  parameter int unsigned DEPTH = 144000,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/tlfb_ctrl.sv =====
// Scan position, fill state and layer write control
`timescale 1ns / 1ps
`include "assert_macros.svh"
module tlfb_ctrl #(
  parameter int unsigned SCREEN_WIDTH  = 400,
  parameter int unsigned SCREEN_HEIGHT = 360,
  parameter int unsigned FILL_CYCLES   = 14400,
  localparam int unsigned PIX = SCREEN_WIDTH * SCREEN_HEIGHT,
  localparam int unsigned AW  = $clog2(PIX)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  logic                          drawing_active_i,
  input  logic                          write_enable_i,
  input  logic                          write_layer_i,
  input  logic [tlfb_pkg::WORD_W-1:0]   write_word_i,
  input  logic [tlfb_pkg::COLOR_W-1:0]  pixel_value_i,
  output logic [AW-1:0]                 rd_addr_o,
  output tlfb_pkg::tlfb_we_t            we_o,
  output logic [AW-1:0]                 bg_waddr_o,
  output logic [AW-1:0]                 fg_waddr_o,
  output logic [tlfb_pkg::COLOR_W-1:0]  wdata_o,
  output logic                          busy_o
);
  import tlfb_pkg::*;

  localparam int unsigned CW = $clog2(FILL_CYCLES + 1);
  localparam logic [COORD_W-1:0] RIGHT_MAX  = COORD_W'(SCREEN_WIDTH - 1);
  localparam logic [COORD_W-1:0] BOTTOM_MAX = COORD_W'(SCREEN_HEIGHT - 1);
  localparam logic [AW-1:0]      LAST_PIX   = AW'(PIX - 1);

  logic [AW-1:0]      scan_q, scan_d;
  logic [COORD_W-1:0] col_q, col_d, row_q, row_d;
  logic [COORD_W-1:0] lft_q, lft_d, rgt_q, rgt_d, top_q, top_d, bot_q, bot_d;
  logic               layer_q, layer_d;
  logic [CW-1:0]      cnt_q, cnt_d;

  logic               is_cmd, active, fill_px, fill_bg, fill_fg, in_range;
  logic [COORD_W-1:0] fx, fy;
  logic [CW-1:0]      cnt_dec;

  always_comb begin
    is_cmd  = write_word_i[WORD_W-1 -: 4] == CMD_NIBBLE;
    fx      = write_word_i[CMD_X_LSB +: COORD_W];
    fy      = write_word_i[CMD_Y_LSB +: COORD_W];
    cnt_dec = (cnt_q != '0) ? cnt_q - CW'(1) : '0;

    lft_d   = lft_q;
    rgt_d   = rgt_q;
    top_d   = top_q;
    bot_d   = bot_q;
    layer_d = layer_q;
    cnt_d   = cnt_dec;
    if (is_cmd) begin
      lft_d   = write_word_i[CMD_LEFT_BIT] ? '0 : fx;
      rgt_d   = write_word_i[CMD_LEFT_BIT] ? fx : RIGHT_MAX;
      top_d   = write_word_i[CMD_TOP_BIT] ? '0 : fy;
      bot_d   = write_word_i[CMD_TOP_BIT] ? fy : BOTTOM_MAX;
      layer_d = write_word_i[CMD_LAYER_BIT];
      cnt_d   = CW'(FILL_CYCLES);
    end
    active  = cnt_d != '0;

    fill_px = active && (col_q > lft_d) && (col_q < rgt_d) &&
              (row_q > top_d) && (row_q < bot_d);
    fill_bg = fill_px && !layer_d;
    fill_fg = fill_px && layer_d;

    in_range = write_word_i < WORD_W'(PIX);
    we_o.bg  = fill_bg || (write_enable_i && !write_layer_i && in_range);
    we_o.fg  = fill_fg || (write_enable_i && write_layer_i && in_range);
    bg_waddr_o = fill_bg ? scan_q : write_word_i[AW-1:0];
    fg_waddr_o = fill_fg ? scan_q : write_word_i[AW-1:0];

    scan_d = scan_q;
    col_d  = col_q;
    row_d  = row_q;
    if (scan_q == LAST_PIX) begin
      scan_d = '0;
      col_d  = '0;
      row_d  = '0;
    end else if (drawing_active_i) begin
      scan_d = scan_q + AW'(1);
      if (col_q == RIGHT_MAX) begin
        col_d = '0;
        row_d = row_q + COORD_W'(1);
      end else begin
        col_d = col_q + COORD_W'(1);
      end
    end
  end

  assign rd_addr_o = scan_q;
  assign wdata_o   = pixel_value_i;
  assign busy_o    = active;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q  <= '0;
      col_q   <= '0;
      row_q   <= '0;
      lft_q   <= '0;
      rgt_q   <= '0;
      top_q   <= '0;
      bot_q   <= '0;
      layer_q <= 1'b0;
      cnt_q   <= '0;
    end else if (accept_i) begin
      scan_q  <= scan_d;
      col_q   <= col_d;
      row_q   <= row_d;
      lft_q   <= lft_d;
      rgt_q   <= rgt_d;
      top_q   <= top_d;
      bot_q   <= bot_d;
      layer_q <= layer_d;
      cnt_q   <= cnt_d;
    end
  end

  `TLFB_ASSERT(a_cmd_arms_fill, accept_i && is_cmd |=> cnt_q != '0, "fill command did not arm")
  `TLFB_ASSERT(a_scan_coords, int'(scan_q) == int'(row_q) * SCREEN_WIDTH + int'(col_q), "scan coordinates out of step")

endmodule

// ===== rtl/tlfb_out.sv =====
// Palette registers, compositing and result item register
`timescale 1ns / 1ps
`include "assert_macros.svh"
module tlfb_out (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          acc_i,
  input  logic                          busy_i,
  input  logic [tlfb_pkg::COLOR_W-1:0]  bg_i,
  input  logic [tlfb_pkg::COLOR_W-1:0]  fg_i,
  output logic                          in_ready_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tlfb_pkg::APB_AW-1:0]   paddr,
  input  logic [tlfb_pkg::APB_DW-1:0]   pwdata,
  output logic [tlfb_pkg::APB_DW-1:0]   prdata,
  output logic                          pready,
  tlfb_out_if.source                    out_o
);
  import tlfb_pkg::*;

  logic [RGB_W-1:0]   pal_q [PAL_SIZE];
  tlfb_reg_e          reg_idx;
  logic               s1_valid_q, s1_valid_d, s1_busy_q, s1_adv;
  logic               out_valid_q, out_valid_d, out_busy_q;
  logic [RGB_W-1:0]   out_rgb_q;
  logic [COLOR_W-1:0] color;

  assign reg_idx = tlfb_reg_e'(paddr[APB_AW-1:2]);
  assign pready  = 1'b1;
  assign prdata  = APB_DW'(pal_q[reg_idx]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pal_q[PAL_ZERO]  <= PAL_RESET_ZERO;
      pal_q[PAL_ONE]   <= PAL_RESET_ONE;
      pal_q[PAL_TWO]   <= PAL_RESET_TWO;
      pal_q[PAL_THREE] <= PAL_RESET_THREE;
    end else if (psel && penable && pwrite) begin
      pal_q[reg_idx] <= pwdata[RGB_W-1:0];
    end
  end

  always_comb begin
    s1_adv      = s1_valid_q && (!out_valid_q || out_o.ready);
    in_ready_o  = !s1_valid_q || s1_adv;
    s1_valid_d  = acc_i ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_q);
    out_valid_d = s1_adv ? 1'b1 : (out_o.ready ? 1'b0 : out_valid_q);
    color       = (fg_i != '0) ? fg_i : bg_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s1_busy_q   <= 1'b0;
      out_valid_q <= 1'b0;
      out_busy_q  <= 1'b0;
      out_rgb_q   <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (acc_i) begin
        s1_busy_q <= busy_i;
      end
      if (s1_adv) begin
        out_busy_q <= s1_busy_q;
        out_rgb_q  <= pal_q[color];
      end
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.rgb_color = out_rgb_q;
  assign out_o.fill_busy = out_busy_q;

  `TLFB_ASSERT(a_hold_read_data, s1_valid_q && !s1_adv |-> !acc_i, "item taken over stalled read data")
  `TLFB_ASSERT(a_out_loads, s1_adv |=> out_valid_q, "advanced item not presented")

endmodule

// ===== rtl/two_layer_framebuffer_fill_scanout.sv =====
// Top level of the two-layer framebuffer with rectangle fill and scanout
//
//   channel  | dir | handshake         | payload
//   in_i     | in  | valid/ready       | drawing_active, write_enable, write_layer,
//            |     |                   | write_word, pixel_value
//   out_o    | out | valid/ready       | rgb_color, fill_busy
//   apb      | in  | psel/penable      | paddr, pwdata, prdata (palette entries)
//
// One item per cycle sustained while out_o results are taken; a taken item passes through
// the registered layer read and then the result register before its result is offered.
// Reset clears scan and fill state and loads the palette; layer RAMs are not cleared.
// A stalled result holds the read stage; input stalls only once both stages are full.
`timescale 1ns / 1ps
module two_layer_framebuffer_fill_scanout #(
  parameter int unsigned SCREEN_WIDTH  = 400,
  parameter int unsigned SCREEN_HEIGHT = 360,
  parameter int unsigned FILL_CYCLES   = 14400
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  tlfb_in_if.sink                      in_i,
  tlfb_out_if.source                   out_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [tlfb_pkg::APB_AW-1:0]  paddr,
  input  logic [tlfb_pkg::APB_DW-1:0]  pwdata,
  output logic [tlfb_pkg::APB_DW-1:0]  prdata,
  output logic                         pready
);
  import tlfb_pkg::*;

  localparam int unsigned PIX = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int unsigned AW  = $clog2(PIX);

  logic               accept, in_ready, busy;
  tlfb_we_t           we;
  logic [AW-1:0]      rd_addr, bg_waddr, fg_waddr;
  logic [COLOR_W-1:0] wdata, bg_rdata, fg_rdata;

  assign in_i.ready = in_ready;
  assign accept     = in_i.valid && in_ready;

  tlfb_ctrl #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT),
    .FILL_CYCLES   (FILL_CYCLES)
  ) u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .accept_i         (accept),
    .drawing_active_i (in_i.drawing_active),
    .write_enable_i   (in_i.write_enable),
    .write_layer_i    (in_i.write_layer),
    .write_word_i     (in_i.write_word),
    .pixel_value_i    (in_i.pixel_value),
    .rd_addr_o        (rd_addr),
    .we_o             (we),
    .bg_waddr_o       (bg_waddr),
    .fg_waddr_o       (fg_waddr),
    .wdata_o          (wdata),
    .busy_o           (busy)
  );

  tlfb_ram #(
    .WIDTH (COLOR_W),
    .DEPTH (PIX)
  ) u_bg_ram (
    .clk_i   (clk_i),
    .we_i    (accept && we.bg),
    .waddr_i (bg_waddr),
    .wdata_i (wdata),
    .re_i    (accept),
    .raddr_i (rd_addr),
    .rdata_o (bg_rdata)
  );

  tlfb_ram #(
    .WIDTH (COLOR_W),
    .DEPTH (PIX)
  ) u_fg_ram (
    .clk_i   (clk_i),
    .we_i    (accept && we.fg),
    .waddr_i (fg_waddr),
    .wdata_i (wdata),
    .re_i    (accept),
    .raddr_i (rd_addr),
    .rdata_o (fg_rdata)
  );

  tlfb_out u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .acc_i      (accept),
    .busy_i     (busy),
    .bg_i       (bg_rdata),
    .fg_i       (fg_rdata),
    .in_ready_o (in_ready),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .out_o      (out_o)
  );

endmodule
